[rtl/spq_pkg.sv]
// Package for the sorted priority queue: capacity, widths, codes and the
// structs passed between the queue control and the row of storage cells.
// No dependencies.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Broadcast to every cell in the accepting cycle.
    typedef struct packed {
        logic                    ins;   // insert taken, store not full
        logic                    rem;   // remove taken, store not empty
        logic signed [KEY_W-1:0] key;   // key being inserted
    } t_cell_cmd;

    // Handed from a cell to its right neighbor.
    typedef struct packed {
        logic                    go;    // new key lands at or left of here
        logic signed [KEY_W-1:0] key;   // current contents of the cell
    } t_link;

endpackage

[rtl/spq_cell.sv]
// One storage cell of the sorted queue: holds one key, compares it with
// the broadcast key and shifts left or right with its neighbors.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic                    i_occ,
    input  t_link                   i_left,
    input  logic signed [KEY_W-1:0] i_right_key,
    output t_link                   o_link,
    output logic signed [KEY_W-1:0] o_next_key
);

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    w_go;

    // Empty slot or strictly greater key: the new key goes here or earlier.
    assign w_go = !i_occ || (i_cmd.key < r_key);

    always_comb begin
        n_key = r_key;
        if (i_cmd.ins && w_go) begin
            n_key = i_left.go ? i_left.key : i_cmd.key;
        end else if (i_cmd.rem) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_link.go   = w_go;
    assign o_link.key  = r_key;
    assign o_next_key  = n_key;

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue, top level: fill counter, handshakes, result
// register and the row of CAPACITY storage cells. Depends on spq_pkg, spq_cell.
//
// Bounded min-priority queue of signed 32-bit keys kept in ascending order
// across a row of cells. Each input item inserts i_key (i_op = 0) or
// removes the smallest key (i_op = 1); equal keys leave in arrival order.
// For every item, all cells compare against the new key at once and
// shift one place in the same edge, so a new item is accepted in every
// cycle in which the result register is empty or being drained.
// Each item yields one result item, registered, in the cycle after
// acceptance: status (0 done, 1 insert refused on full, 2 remove refused
// on empty), the smallest key after the step (0 when empty), the count and
// an empty flag. Refused items leave the store untouched. Stored keys are
// not cleared by reset; only the fill count and result valid flag are,
// and slots past the fill count are never reported.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_op,
    input  logic signed [KEY_W-1:0] i_key,
    // result items
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_status,
    output logic signed [KEY_W-1:0] o_min_key,
    output logic [COUNT_W-1:0]      o_count,
    output logic                    o_is_empty
);

    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic                    r_out_valid;
    logic [1:0]              r_status;
    logic signed [KEY_W-1:0] r_min_key;
    logic [COUNT_W-1:0]      r_count;
    logic                    r_is_empty;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_status   w_status;
    t_cell_cmd w_cmd;

    t_link                   w_link [CAPACITY];
    logic signed [KEY_W-1:0] w_next_key [CAPACITY];
    logic                    w_occ [CAPACITY];

    // Result register frees up when drained, so accept alongside the drain.
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_full  = (r_fill == FILL_W'(CAPACITY));
    assign w_empty = (r_fill == '0);

    always_comb begin
        w_cmd.key = i_key;
        w_cmd.ins = w_accept && (t_op'(i_op) == OP_INSERT) && !w_full;
        w_cmd.rem = w_accept && (t_op'(i_op) == OP_REMOVE) && !w_empty;
    end

    always_comb begin
        case (t_op'(i_op))
            OP_INSERT: w_status = w_full  ? ST_FULL  : ST_DONE;
            OP_REMOVE: w_status = w_empty ? ST_EMPTY : ST_DONE;
            default:   w_status = ST_DONE;
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        if (w_cmd.ins) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (w_cmd.rem) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    // Cell row: cell 0 holds the minimum. Left edge never forwards, the
    // last cell refills from itself on a remove (slot then lies past fill).
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link                   w_left;
        logic signed [KEY_W-1:0] w_right_key;

        assign w_occ[g] = (FILL_W'(g) < r_fill);

        if (g == 0) begin : g_first
            assign w_left.go  = 1'b0;
            assign w_left.key = i_key;
        end else begin : g_mid
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = w_link[g].key;
        end else begin : g_inner
            assign w_right_key = w_link[g+1].key;
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occ       (w_occ[g]),
            .i_left      (w_left),
            .i_right_key (w_right_key),
            .o_link      (w_link[g]),
            .o_next_key  (w_next_key[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, state after the step.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= w_status;
            r_min_key  <= (n_fill != '0) ? w_next_key[0] : '0;
            r_count    <= COUNT_W'(n_fill);
            r_is_empty <= (n_fill == '0);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_min_key  = r_min_key;
    assign o_count    = r_count;
    assign o_is_empty = r_is_empty;

endmodule
